// ----- src/scmd_pkg.sv -----
package scmd_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h6f63;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [3:0]  POS_FIRST  = 4'd0;
    localparam logic [3:0]  POS_ID_HI  = 4'd2;
    localparam logic [3:0]  POS_FLAGS  = 4'd3;
    localparam logic [3:0]  POS_CONS_2 = 4'd4;
    localparam logic [3:0]  POS_CONS_1 = 4'd5;
    localparam logic [3:0]  POS_CONS_0 = 4'd6;
    localparam logic [3:0]  POS_ID_2   = 4'd7;
    localparam logic [3:0]  POS_ID_1   = 4'd8;
    localparam logic [3:0]  POS_ID_0   = 4'd9;
    localparam logic [3:0]  POS_CRC_HI = 4'd10;
    localparam logic [3:0]  POS_LAST   = 4'd11;
    localparam logic [3:0]  POS_IDLE   = 4'd12;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = 6;

    typedef struct packed {
        logic [15:0] sent_checksum;
        logic [1:0]  tamper_encoder;
        logic [1:0]  tamper_physical;
        logic [3:0]  meter_type;
        logic [23:0] consumption;
        logic [25:0] meter_id;
    } t_fields;

    typedef struct packed {
        t_fields fields;
        logic    crc_ok;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic       frame_start;
        logic [7:0] data_byte;
    } t_in_word;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- src/scm_meter_frame_decoder.sv -----
// scm meter frame decoder
//
// input stream: one byte of a 12-byte scm frame per word, msb first, on
// s_axis_tdata; s_axis_tuser marks byte 0 of a new frame and restarts the
// byte count. bytes 2..11 run through a crc-16 (poly 0x6f63, init 0).
// output stream: one word per frame after byte 11 with the meter id,
// consumption, type, tamper fields and sent crc on m_axis_tdata and the
// crc check result on m_axis_tuser. failing frames are still reported.
// bytes after byte 11 without a frame start are dropped.
//
// path: byte 11 is held in the input register, then passes through decode
// and crc logic into the result register.
// throughput: one byte per cycle while the output is not stalled, limited by the single-byte crc update.
// reset: pipeline empties, byte count returns to 0, so the first byte
// after reset counts as byte 0.
// stall: the result register holds while m_axis_tready is low; input is
// still taken while the result register is empty or being drained.
module scm_meter_frame_decoder
    import scmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // data_byte
    input  logic                  s_axis_tuser,  // frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // meter_id, consumption, meter_type, tamper_physical, tamper_encoder,
    // sent_checksum, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser   // crc_ok
);

    t_in_word in_word;
    logic     advance;
    logic     out_free;
    logic     result_valid;
    t_result  result;

    logic     r_out_valid;
    t_result  r_out;

    assign out_free = !r_out_valid || m_axis_tready;
    assign advance  = in_word.valid && out_free;

    scmd_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_data_byte  (s_axis_tdata),
        .i_frame_start(s_axis_tuser),
        .i_advance    (advance),
        .o_ready      (s_axis_tready),
        .o_word       (in_word)
    );

    scmd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_word        (in_word),
        .o_result_valid(result_valid),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && result_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result_valid) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.fields};
    assign m_axis_tuser  = r_out.crc_ok;

endmodule

// ----- src/scmd_in_stage.sv -----
module scmd_in_stage
    import scmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    input  logic       i_advance,
    output logic       o_ready,
    output t_in_word   o_word
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_frame_start;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data_byte   <= i_data_byte;
            r_frame_start <= i_frame_start;
        end
    end

    assign o_word = '{valid: r_valid, frame_start: r_frame_start, data_byte: r_data_byte};

endmodule

// ----- src/scmd_core.sv -----
module scmd_core
    import scmd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_word i_word,
    output logic     o_result_valid,
    output t_result  o_result
);

    logic [3:0]  r_pos;
    logic [15:0] r_crc;
    logic [25:0] r_id;
    logic [23:0] r_cons;
    logic [7:0]  r_flags;
    logic [7:0]  r_crc_hi;

    logic [3:0]  n_pos;
    logic [15:0] n_crc;
    logic [25:0] n_id;
    logic [23:0] n_cons;
    logic [7:0]  n_flags;
    logic [7:0]  n_crc_hi;

    logic [3:0]  pos;
    logic [7:0]  b;
    logic [15:0] crc_next;

    assign b        = i_word.data_byte;
    assign pos      = i_word.frame_start ? POS_FIRST : r_pos;
    assign crc_next = crc_feed(r_crc, b);

    always_comb begin
        n_pos          = r_pos;
        n_crc          = r_crc;
        n_id           = r_id;
        n_cons         = r_cons;
        n_flags        = r_flags;
        n_crc_hi       = r_crc_hi;
        o_result_valid = 1'b0;
        if (pos >= POS_IDLE) begin
            n_pos = POS_IDLE;
        end else if (pos < POS_ID_HI) begin
            n_crc = CRC_INIT;
            n_pos = pos + 4'd1;
        end else begin
            n_crc = crc_next;
            case (pos)
                POS_ID_HI:  n_id[25:24]   = b[2:1];
                POS_FLAGS:  n_flags       = b;
                POS_CONS_2: n_cons[23:16] = b;
                POS_CONS_1: n_cons[15:8]  = b;
                POS_CONS_0: n_cons[7:0]   = b;
                POS_ID_2:   n_id[23:16]   = b;
                POS_ID_1:   n_id[15:8]    = b;
                POS_ID_0:   n_id[7:0]     = b;
                POS_CRC_HI: n_crc_hi      = b;
                default:    n_crc_hi      = r_crc_hi;
            endcase
            if (pos == POS_LAST) begin
                n_pos          = POS_IDLE;
                o_result_valid = 1'b1;
            end else begin
                n_pos = pos + 4'd1;
            end
        end
    end

    assign o_result.fields.meter_id        = r_id;
    assign o_result.fields.consumption     = r_cons;
    assign o_result.fields.meter_type      = r_flags[5:2];
    assign o_result.fields.tamper_physical = r_flags[7:6];
    assign o_result.fields.tamper_encoder  = r_flags[1:0];
    assign o_result.fields.sent_checksum   = {r_crc_hi, b};
    assign o_result.crc_ok                 = (crc_next == 16'h0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
            r_crc <= CRC_INIT;
        end else if (i_advance) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_id     <= n_id;
            r_cons   <= n_cons;
            r_flags  <= n_flags;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

// ----- src/scmd_checker.sv -----
module scmd_checker
    import scmd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_rise_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a byte taken two cycles earlier");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

endmodule

bind scm_meter_frame_decoder scmd_checker u_scmd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
